/* hw/rtl/mst_pkg.sv */
// Package with the shared types, codes and defaults of the membership set table.
`timescale 1ns / 1ps

package mst_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_WIDTH_DEF = 32;

	localparam int KEY_IN_W = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;

	localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;

	// Token that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic active;
		logic hit;
		logic free;
	} token_t;

	// Update broadcast to all cells when a request finishes.
	typedef struct packed {
		logic insert;
		logic remove;
	} cmd_t;

endpackage

/* hw/rtl/mst_req_if.sv */
// Request channel of the membership set table.
`timescale 1ns / 1ps

interface mst_req_if;
	logic                              valid;
	logic                              ready;
	logic [mst_pkg::ACTION_W-1:0]      action;
	logic [mst_pkg::KEY_IN_W-1:0]      key;

	modport source (output valid, output action, output key, input ready);
	modport sink (input valid, input action, input key, output ready);
endinterface

/* hw/rtl/mst_rsp_if.sv */
// Response channel of the membership set table.
`timescale 1ns / 1ps

interface mst_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [mst_pkg::STATUS_W-1:0]      status;
	logic                              found;
	logic [mst_pkg::COUNT_W-1:0]       member_count;

	modport source (output valid, output status, output found, output member_count,
		input ready);
	modport sink (input valid, input status, input found, input member_count,
		output ready);
endinterface

/* hw/rtl/mst_cell.sv */
// One storage cell of the set table: holds an entry and passes the search token on.
`timescale 1ns / 1ps

module mst_cell #(
	parameter int KEY_WIDTH = mst_pkg::KEY_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [KEY_WIDTH-1:0] key,
	input  mst_pkg::token_t      tok_in,
	output mst_pkg::token_t      tok_out,
	input  mst_pkg::cmd_t        cmd
);

	logic [KEY_WIDTH-1:0] entry_key_q;
	logic                 valid_q;
	logic                 mark_hit_q;
	logic                 mark_free_q;
	mst_pkg::token_t      tok_q;
	logic                 match;

	assign match   = valid_q && (entry_key_q == key);
	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			mark_hit_q  <= 1'b0;
			mark_free_q <= 1'b0;
			tok_q       <= '0;
		end else begin
			if (tok_in.active) begin
				tok_q.active <= 1'b1;
				tok_q.hit    <= tok_in.hit | match;
				tok_q.free   <= tok_in.free | !valid_q;
				// This cell is the first match or the lowest free entry of the walk.
				mark_hit_q   <= !tok_in.hit && match;
				mark_free_q  <= !tok_in.free && !valid_q;
			end else begin
				tok_q <= '0;
			end
			if (cmd.insert && mark_free_q) begin
				valid_q <= 1'b1;
			end else if (cmd.remove && mark_hit_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && mark_free_q) begin
			entry_key_q <= key;
		end
	end

endmodule

/* hw/rtl/membership_set_table.sv */
// Top level of the membership set table: cell chain, request control and result register.
//
//   channel | direction | payload                       | accepted when
//   req     | in        | action, key                   | req.valid && req.ready
//   rsp     | out       | status, found, member_count   | rsp.valid && rsp.ready
//
// Between acceptance and the next possible one, the registered request launches
// the search token, which passes the cell chain one cell per cycle; then res_q
// captures the result, and the finish step commits the update and loads the
// response.
// Reset clears every valid mark, the member count and the response valid flag.
// A held response does not block acceptance; a finished search waits for the
// response register to empty before it commits.
`timescale 1ns / 1ps

module membership_set_table #(
	parameter int CAPACITY  = mst_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = mst_pkg::KEY_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mst_req_if.sink   req,
	mst_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_WALK   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t                          state_q;
	logic [KEY_WIDTH-1:0]            key_q;
	logic [mst_pkg::ACTION_W-1:0]    action_q;
	logic                            start_q;
	mst_pkg::token_t                 res_q;
	logic [CNT_W-1:0]                count_q;
	logic                            rsp_valid_q;
	logic [mst_pkg::STATUS_W-1:0]    status_q;
	logic                            found_q;
	logic [mst_pkg::COUNT_W-1:0]     member_count_q;

	mst_pkg::token_t                 tok [CAPACITY+1];
	mst_pkg::cmd_t                   cmd;
	logic                            accept;
	logic                            finish_go;
	logic                            do_insert;
	logic                            do_remove;
	logic [mst_pkg::STATUS_W-1:0]    status_nxt;
	logic [CNT_W-1:0]                count_nxt;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// The token starts in the cycle after acceptance, once the key register holds the request.
	assign tok[0].active = start_q;
	assign tok[0].hit    = 1'b0;
	assign tok[0].free   = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mst_cell #(
			.KEY_WIDTH (KEY_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (key_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.cmd     (cmd)
		);
	end

	always_comb begin
		do_insert  = 1'b0;
		do_remove  = 1'b0;
		status_nxt = mst_pkg::ST_ABSENT;
		case (action_q)
			mst_pkg::ACT_INSERT: begin
				if (res_q.hit) begin
					status_nxt = mst_pkg::ST_DUP;
				end else if (res_q.free) begin
					status_nxt = mst_pkg::ST_ADDED;
					do_insert  = 1'b1;
				end else begin
					status_nxt = mst_pkg::ST_FULL;
				end
			end
			mst_pkg::ACT_REMOVE: begin
				if (res_q.hit) begin
					status_nxt = mst_pkg::ST_REMOVED;
					do_remove  = 1'b1;
				end else begin
					status_nxt = mst_pkg::ST_NOTFOUND;
				end
			end
			default: begin
				status_nxt = res_q.hit ? mst_pkg::ST_PRESENT : mst_pkg::ST_ABSENT;
			end
		endcase
	end

	assign finish_go  = (state_q == S_FINISH) && (!rsp_valid_q || rsp.ready);
	assign cmd.insert = finish_go && do_insert;
	assign cmd.remove = finish_go && do_remove;
	assign count_nxt  = count_q + CNT_W'(do_insert) - CNT_W'(do_remove);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			start_q <= accept;
			if (finish_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (tok[CAPACITY].active) begin
						res_q   <= tok[CAPACITY];
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish_go) begin
						count_q <= count_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= KEY_WIDTH'(req.key);
			action_q <= req.action;
		end
		if (finish_go) begin
			status_q       <= status_nxt;
			found_q        <= res_q.hit;
			member_count_q <= mst_pkg::COUNT_W'(count_nxt);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.found        = found_q;
	assign rsp.member_count = member_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("member count exceeds capacity");

	a_token_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tok[CAPACITY].active |-> state_q == S_WALK)
		else $error("search token left the chain outside a walk");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> count_q != CNT_W'(CAPACITY))
		else $error("insert committed into a full table");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_FINISH))
		else $error("response loaded outside the finish step");

	a_single_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.insert && cmd.remove))
		else $error("insert and remove committed together");
`endif

endmodule
